[sv/mi_pkg.sv]
// Shared types and constants of the 3x3 matrix inverse block.
`default_nettype none
package mi_pkg;

    localparam int N_ELEM = 9;

    // Operand positions a, b, c, d of each cofactor a*b - c*d, adjugate row-major.
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic neg;
        logic ovf;
    } t_qflags;

endpackage
`default_nettype wire

[sv/mi_cofactor.sv]
// One cofactor lane: a*b - c*d at full precision over two stages.
`default_nettype none
module mi_cofactor #(
    parameter int WORD_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_ce,
    input  wire signed [WORD_BITS-1:0]   i_a,
    input  wire signed [WORD_BITS-1:0]   i_b,
    input  wire signed [WORD_BITS-1:0]   i_c,
    input  wire signed [WORD_BITS-1:0]   i_d,
    output logic signed [2*WORD_BITS:0] o_cof
);
    logic signed [2*WORD_BITS-1:0] r_p;
    logic signed [2*WORD_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p   <= i_a * i_b;
            r_q   <= i_c * i_d;
            o_cof <= {r_p[2*WORD_BITS-1], r_p} - {r_q[2*WORD_BITS-1], r_q};
        end
    end
endmodule
`default_nettype wire

[sv/mi_div_lane.sv]
// Pipelined restoring divider lane: one quotient bit per stage plus an overflow stage.
`default_nettype none
module mi_div_lane #(
    parameter int WORD_BITS = 32,
    parameter int NUM_BITS  = 97,
    parameter int DEN_BITS  = 99
) (
    input  wire                  i_clk,
    input  wire                  i_ce,
    input  wire [NUM_BITS-1:0]   i_num,
    input  wire [DEN_BITS-1:0]   i_den,
    input  wire                  i_neg,
    output logic [WORD_BITS-1:0] o_mag,
    output mi_pkg::t_qflags      o_flags
);
    localparam int RW0 = (NUM_BITS > DEN_BITS + WORD_BITS) ? NUM_BITS : DEN_BITS + WORD_BITS;
    localparam int RW  = RW0 + 1;

    logic [RW-1:0]        r_rem [0:WORD_BITS];
    logic [DEN_BITS-1:0]  r_den [0:WORD_BITS];
    logic [WORD_BITS-1:0] r_q   [0:WORD_BITS];
    mi_pkg::t_qflags      r_fl  [0:WORD_BITS];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]     <= RW'(i_num);
            r_den[0]     <= i_den;
            r_q[0]       <= '0;
            r_fl[0].neg  <= i_neg;
            r_fl[0].ovf  <= RW'(i_num) >= (RW'(i_den) << WORD_BITS);
        end
    end

    for (genvar j = 1; j <= WORD_BITS; j++) begin : g_stage
        localparam int SH = WORD_BITS - j;
        logic [RW-1:0] w_sub;
        logic          w_ge;
        assign w_sub = RW'(r_den[j-1]) << SH;
        assign w_ge  = r_rem[j-1] >= w_sub;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[j] <= w_ge ? r_rem[j-1] - w_sub : r_rem[j-1];
                r_den[j] <= r_den[j-1];
                r_q[j]   <= r_q[j-1] | (WORD_BITS'(w_ge) << SH);
                r_fl[j]  <= r_fl[j-1];
            end
        end
    end

    assign o_mag   = r_q[WORD_BITS];
    assign o_flags = r_fl[WORD_BITS];
endmodule
`default_nettype wire

[sv/matrix_inverse_3x3.sv]
// Top level of the 3x3 fixed-point matrix inverse (adjugate over determinant).
// Input channel i_s_*: one word per matrix, nine signed elements a00..a22.
// Output channel o_m_*: the nine inverse elements, the determinant, and the
// singular flag on o_m_tuser. All values are saturated to the word range.
// A word is moved when tvalid and tready are both high at a rising edge.
// The pipeline is built from the cofactor, determinant and normalization stages
// and the nine divider lanes, which resolve one quotient bit per stage.
// Throughput is one matrix per cycle while the receiver keeps i_m_tready high.
// When the receiver stalls, the whole pipeline holds; one more input word is
// taken into a skid register and o_s_tready then drops until the stall ends.
// A singular matrix returns zero inverse elements and the singular flag set.
// Reset clears the valid flags of all stages, of the skid register and of the output.
`default_nettype none
module matrix_inverse_3x3 #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_s_tvalid,
    output logic                                      o_s_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up.
    input  wire [((9*WORD_BITS+7)/8)*8-1:0]           i_s_tdata,
    output logic                                      o_m_tvalid,
    input  wire                                       i_m_tready,
    // inv00 .. inv22, then determinant, from the lowest bit up.
    output logic [((10*WORD_BITS+7)/8)*8-1:0]         o_m_tdata,
    // singular.
    output logic                                      o_m_tuser
);
    localparam int W      = WORD_BITS;
    localparam int CW     = 2*W + 1;
    localparam int DETW   = 3*W + 3;
    localparam int NMW    = CW + 2*FRAC_BITS;
    localparam int IW     = ((9*W+7)/8)*8;
    localparam int OW     = ((10*W+7)/8)*8;
    localparam int NST    = 6 + W + 1;

    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat(input logic neg, input logic ovf,
                                         input logic [W-1:0] mag);
        logic [W-1:0] res;
        if (ovf) begin
            res = neg ? SAT_MIN : SAT_MAX;
        end else if (!neg) begin
            res = mag[W-1] ? SAT_MAX : mag;
        end else begin
            res = (mag[W-1] && (|mag[W-2:0])) ? SAT_MIN : (~mag + W'(1));
        end
        return res;
    endfunction

    logic w_ce;
    assign w_ce = !o_m_tvalid || i_m_tready;

    // Input skid register.
    logic          r_sk_valid;
    logic [IW-1:0] r_sk_data;
    logic          w_s_fire;
    assign o_s_tready = !r_sk_valid;
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    logic [NST-1:0]      r_vs;
    logic signed [W-1:0] r_m [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_valid <= 1'b0;
            r_vs       <= '0;
        end else if (w_ce) begin
            r_sk_valid <= 1'b0;
            r_vs       <= {r_vs[NST-2:0], r_sk_valid | w_s_fire};
        end else if (w_s_fire) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_ce && w_s_fire) begin
            r_sk_data <= i_s_tdata;
        end
        if (w_ce) begin
            for (int k = 0; k < 9; k++) begin
                r_m[k] <= r_sk_valid ? r_sk_data[k*W +: W] : i_s_tdata[k*W +: W];
            end
        end
    end

    // Cofactor lanes.
    logic signed [CW-1:0] w_adj [9];
    for (genvar k = 0; k < 9; k++) begin : g_cof
        mi_cofactor #(.WORD_BITS(W)) u_cof (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_a   (r_m[mi_pkg::COF_IDX[k][0]]),
            .i_b   (r_m[mi_pkg::COF_IDX[k][1]]),
            .i_c   (r_m[mi_pkg::COF_IDX[k][2]]),
            .i_d   (r_m[mi_pkg::COF_IDX[k][3]]),
            .o_cof (w_adj[k])
        );
    end

    // First-row elements delayed to line up with the cofactors.
    logic signed [W-1:0]  r_row1 [3];
    logic signed [W-1:0]  r_row2 [3];
    logic signed [2*W:0]  r_plo  [3];
    logic signed [2*W:0]  r_phi  [3];
    logic signed [CW-1:0] r_adj3 [9];
    logic signed [CW-1:0] r_adj4 [9];
    logic signed [DETW-1:0] r_det;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < 3; k++) begin
                r_row1[k] <= r_m[k];
                r_row2[k] <= r_row1[k];
            end
            r_plo[0] <= r_row2[0] * $signed({1'b0, w_adj[0][W-1:0]});
            r_phi[0] <= r_row2[0] * $signed(w_adj[0][CW-1:W]);
            r_plo[1] <= r_row2[1] * $signed({1'b0, w_adj[3][W-1:0]});
            r_phi[1] <= r_row2[1] * $signed(w_adj[3][CW-1:W]);
            r_plo[2] <= r_row2[2] * $signed({1'b0, w_adj[6][W-1:0]});
            r_phi[2] <= r_row2[2] * $signed(w_adj[6][CW-1:W]);
            for (int k = 0; k < 9; k++) begin
                r_adj3[k] <= w_adj[k];
                r_adj4[k] <= r_adj3[k];
            end
            r_det <= (DETW'(r_phi[0]) <<< W) + DETW'(r_plo[0])
                   + (DETW'(r_phi[1]) <<< W) + DETW'(r_plo[1])
                   + (DETW'(r_phi[2]) <<< W) + DETW'(r_plo[2]);
        end
    end

    // Magnitudes and signs for the divider lanes.
    logic [DETW-1:0] w_det_mag;
    logic [DETW-1:0] w_det_sh;
    logic [DETW-1:0] r_det_mag;
    logic            r_sing  [0:W+1];
    logic [W-1:0]    r_dsat  [0:W+1];
    logic [NMW-1:0]  r_num   [9];
    logic            r_qneg  [9];

    assign w_det_mag = r_det[DETW-1] ? DETW'(-r_det) : DETW'(r_det);
    assign w_det_sh  = w_det_mag >> (2*FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_det_mag <= w_det_mag;
            r_sing[0] <= (r_det == '0);
            r_dsat[0] <= sat(r_det[DETW-1], |w_det_sh[DETW-1:W], w_det_sh[W-1:0]);
            for (int k = 0; k < 9; k++) begin
                r_num[k]  <= NMW'(r_adj4[k][CW-1] ? CW'(-r_adj4[k]) : CW'(r_adj4[k]))
                             << (2*FRAC_BITS);
                r_qneg[k] <= r_adj4[k][CW-1] ^ r_det[DETW-1];
            end
            for (int k = 1; k <= W+1; k++) begin
                r_sing[k] <= r_sing[k-1];
                r_dsat[k] <= r_dsat[k-1];
            end
        end
    end

    logic [W-1:0]    w_qmag [9];
    mi_pkg::t_qflags w_qfl  [9];
    for (genvar k = 0; k < 9; k++) begin : g_div
        mi_div_lane #(.WORD_BITS(W), .NUM_BITS(NMW), .DEN_BITS(DETW)) u_div (
            .i_clk   (i_clk),
            .i_ce    (w_ce),
            .i_num   (r_num[k]),
            .i_den   (r_det_mag),
            .i_neg   (r_qneg[k]),
            .o_mag   (w_qmag[k]),
            .o_flags (w_qfl[k])
        );
    end

    // Merge stage and output register.
    logic [OW-1:0] n_m_tdata;

    always_comb begin
        n_m_tdata = '0;
        for (int k = 0; k < 9; k++) begin
            n_m_tdata[k*W +: W] = r_sing[W+1] ? '0
                                  : sat(w_qfl[k].neg, w_qfl[k].ovf, w_qmag[k]);
        end
        n_m_tdata[9*W +: W] = r_dsat[W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (w_ce) begin
            o_m_tvalid <= r_vs[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            o_m_tdata <= n_m_tdata;
            o_m_tuser <= r_sing[W+1];
        end
    end

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[10*W-1:0] == '0))
        else $error("singular result with nonzero fields");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("skid register not filled during stall");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_s_tready && (!o_m_tvalid || i_m_tready)) |=> o_s_tready)
        else $error("skid register not drained");
endmodule
`default_nettype wire
